// ===== sv/tcce_pkg.sv =====
package tcce_pkg;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

  localparam int CELL_W     = 16;
  localparam int POS_W      = 11;
  localparam int READ_ROW_W = 5;
  localparam int READ_COL_W = 7;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_RETURN  = 8'h0d;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] BLANK_ATTR   = 8'h07;

  localparam cell_t BLANK_CELL = '{attr: BLANK_ATTR, ch: BLANK_CHAR};

endpackage

// ===== sv/tcce_ram.sv =====
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/text_console_cursor_engine.sv =====
// channel   direction  handshake            payload
// command   in         start && !busy       kind, char_code, attribute, read_row, read_column
// result    out        done (one cycle)     cursor_position, cell_char, cell_attribute
//
// put, delete, carriage return and newline without scroll: from idle straight to the finish state
// read cell: through the read-wait state, for the registered read of the screen memory
// scroll (newline or wrap on the bottom row): move, blank-row, for a wrap the put state, then finish;
//   clear: a sweep over every cell, then finish; one cell per cycle through the single write port
// after reset a clearing pass blanks the screen, busy high
// the receiver cannot stall: done is high for exactly one cycle per transaction
module text_console_cursor_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            kind,
  input  logic [7:0]                            char_code,
  input  logic [7:0]                            attribute,
  input  logic [tcce_pkg::READ_ROW_W-1:0]       read_row,
  input  logic [tcce_pkg::READ_COL_W-1:0]       read_column,
  output logic                                  done,
  output logic [tcce_pkg::POS_W-1:0]            cursor_position,
  output logic [7:0]                            cell_char,
  output logic [7:0]                            cell_attribute
);

  localparam int CELLS      = ROWS * COLUMNS;
  localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELLS);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS + 1);
  localparam int MW         = (AW > 12) ? AW : 12;
  localparam int PW         = (AW > tcce_pkg::POS_W) ? AW : tcce_pkg::POS_W;

  localparam logic [AW-1:0] STRIDE    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_MOVE = AW'(MOVE_CELLS - 1);
  localparam logic [CW-1:0] COL_END   = CW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_MOVE,
    ST_BLANK_ROW,
    ST_PUT,
    ST_READ_WAIT,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [AW-1:0]     base;
  logic [AW-1:0]     sweep;
  logic              put_after_scroll;
  tcce_pkg::cell_t   put_cell;
  logic              read_hit;

  // write stage: one write per cycle, data from the held cell or the memory read
  logic              wr_en_q;
  logic [AW-1:0]     wr_addr_q;
  tcce_pkg::cell_t   wr_data_q;
  logic              wr_from_ram_q;

  tcce_pkg::cell_t   ram_wr_data;
  tcce_pkg::cell_t   ram_rd_data;
  logic [AW-1:0]     ram_rd_addr;

  logic              at_last_row;
  logic              col_full;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     del_addr;
  logic [MW-1:0]     read_full;
  logic              read_in_range;
  logic [CW-1:0]     col_clamped;
  logic [PW-1:0]     pos_sum;

  // the last blanking write after reset lands in the first idle cycle
  assign busy          = (state != ST_IDLE) || wr_en_q;
  assign at_last_row   = (row == ROW_LAST);
  assign col_full      = (col >= COL_END);
  assign cur_addr      = base + AW'(col);
  assign del_addr      = cur_addr - AW'(1);
  assign read_full     = MW'(read_row) * MW'(COLUMNS) + MW'(read_column);
  assign read_in_range = (8'(read_row) < 8'(ROWS)) && (8'(read_column) < 8'(COLUMNS));
  assign ram_rd_addr   = (state == ST_MOVE) ? sweep + STRIDE : read_full[AW-1:0];
  assign ram_wr_data   = wr_from_ram_q ? ram_rd_data : wr_data_q;
  assign col_clamped   = col_full ? COL_LAST : col;
  assign pos_sum       = PW'(base) + PW'(col_clamped);

  tcce_ram #(
    .WIDTH (tcce_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en_q),
    .wr_addr (wr_addr_q),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_INIT;
      sweep            <= '0;
      row              <= '0;
      col              <= '0;
      base             <= '0;
      put_after_scroll <= 1'b0;
      read_hit         <= 1'b0;
      wr_en_q          <= 1'b0;
      wr_from_ram_q    <= 1'b0;
      done             <= 1'b0;
    end else begin
      wr_en_q <= 1'b0;
      done    <= 1'b0;
      unique case (state)
        ST_INIT, ST_CLEAR: begin
          wr_en_q       <= 1'b1;
          wr_addr_q     <= sweep;
          wr_data_q     <= tcce_pkg::BLANK_CELL;
          wr_from_ram_q <= 1'b0;
          sweep         <= sweep + AW'(1);
          if (sweep == LAST_CELL) begin
            sweep <= '0;
            state <= (state == ST_INIT) ? ST_IDLE : ST_FINISH;
          end
        end
        ST_IDLE: begin
          if (start && !wr_en_q) begin
            put_cell       <= '{attr: attribute, ch: char_code};
            cell_char      <= '0;
            cell_attribute <= '0;
            state          <= ST_FINISH;
            unique case (tcce_pkg::kind_t'(kind))
              tcce_pkg::KIND_PUT: begin
                priority if (char_code == tcce_pkg::CHAR_NEWLINE) begin
                  col <= '0;
                  if (at_last_row) begin
                    sweep            <= '0;
                    put_after_scroll <= 1'b0;
                    state            <= ST_MOVE;
                  end else begin
                    row  <= row + RW'(1);
                    base <= base + STRIDE;
                  end
                end else if (char_code == tcce_pkg::CHAR_RETURN) begin
                  col <= '0;
                end else if (col_full && at_last_row) begin
                  // wrap on the bottom row: scroll first, the cell is written afterwards
                  col              <= '0;
                  sweep            <= '0;
                  put_after_scroll <= 1'b1;
                  state            <= ST_MOVE;
                end else if (col_full) begin
                  wr_en_q       <= 1'b1;
                  wr_addr_q     <= base + STRIDE;
                  wr_data_q     <= '{attr: attribute, ch: char_code};
                  wr_from_ram_q <= 1'b0;
                  row           <= row + RW'(1);
                  base          <= base + STRIDE;
                  col           <= CW'(1);
                end else begin
                  wr_en_q       <= 1'b1;
                  wr_addr_q     <= cur_addr;
                  wr_data_q     <= '{attr: attribute, ch: char_code};
                  wr_from_ram_q <= 1'b0;
                  col           <= col + CW'(1);
                end
              end
              tcce_pkg::KIND_DELETE: begin
                if (!((base == '0) && (col == '0))) begin
                  wr_en_q       <= 1'b1;
                  wr_addr_q     <= del_addr;
                  wr_data_q     <= tcce_pkg::BLANK_CELL;
                  wr_from_ram_q <= 1'b0;
                  if (col == '0) begin
                    row  <= row - RW'(1);
                    base <= base - STRIDE;
                    col  <= COL_LAST;
                  end else begin
                    col <= col - CW'(1);
                  end
                end
              end
              tcce_pkg::KIND_CLEAR: begin
                row   <= '0;
                col   <= '0;
                base  <= '0;
                sweep <= '0;
                state <= ST_CLEAR;
              end
              tcce_pkg::KIND_READ: begin
                read_hit <= read_in_range;
                state    <= ST_READ_WAIT;
              end
            endcase
          end
        end
        ST_MOVE: begin
          // read one row below, write back on the next cycle
          wr_en_q       <= 1'b1;
          wr_addr_q     <= sweep;
          wr_from_ram_q <= 1'b1;
          sweep         <= sweep + AW'(1);
          if (sweep == LAST_MOVE) begin
            state <= ST_BLANK_ROW;
          end
        end
        ST_BLANK_ROW: begin
          wr_en_q       <= 1'b1;
          wr_addr_q     <= sweep;
          wr_data_q     <= tcce_pkg::BLANK_CELL;
          wr_from_ram_q <= 1'b0;
          sweep         <= sweep + AW'(1);
          if (sweep == LAST_CELL) begin
            sweep <= '0;
            state <= put_after_scroll ? ST_PUT : ST_FINISH;
          end
        end
        ST_PUT: begin
          wr_en_q       <= 1'b1;
          wr_addr_q     <= base;
          wr_data_q     <= put_cell;
          wr_from_ram_q <= 1'b0;
          col           <= CW'(1);
          state         <= ST_FINISH;
        end
        ST_READ_WAIT: begin
          if (read_hit) begin
            cell_char      <= ram_rd_data.ch;
            cell_attribute <= ram_rd_data.attr;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          done            <= 1'b1;
          cursor_position <= pos_sum[tcce_pkg::POS_W-1:0];
          state           <= ST_IDLE;
        end
      endcase
    end
  end

  a_row_bound: assert property (@(posedge clk) disable iff (rst) row <= ROW_LAST)
    else $error("cursor row beyond the last row");

  a_col_bound: assert property (@(posedge clk) disable iff (rst) col <= COL_END)
    else $error("cursor column beyond the row end");

  a_base_track: assert property (@(posedge clk) disable iff (rst)
    base == AW'(row) * STRIDE)
    else $error("row base out of step with cursor row");

  a_done_from_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a finished transaction");

  a_write_in_screen: assert property (@(posedge clk) disable iff (rst)
    wr_en_q |-> wr_addr_q <= LAST_CELL)
    else $error("screen write outside the cell range");

endmodule
